FILE: src/shcj_pkg.sv
// Shared types, constants and register codes for the stepper homing,
// centering and jog block. No dependencies.
package shcj_pkg;

   localparam int COUNT_BITS_DEF = 24;

   localparam int ACTION_W  = 2;
   localparam int JOY_W     = 10;
   localparam int PERIOD_W  = 16;
   localparam int DEBOUNCE_W = 17;
   localparam int DWELL_W   = 22;
   localparam int FIELD_W   = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 22;

   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_END   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_JOY_HIGH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_JOY_LOW     = 3'd4;

   localparam logic [PERIOD_W-1:0]   STEP_PERIOD_RST = 16'd800;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST    = 17'd50000;
   localparam logic [DWELL_W-1:0]    DWELL_RST       = 22'd2000000;
   localparam logic [JOY_W-1:0]      JOY_HIGH_RST    = 10'd800;
   localparam logic [JOY_W-1:0]      JOY_LOW_RST     = 10'd300;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MAX = '1;

   typedef enum logic [2:0] {
      MODE_SEEK_START  = 3'd0,
      MODE_SEEK_END    = 3'd1,
      MODE_SEEK_MIDDLE = 3'd2,
      MODE_DWELL       = 3'd3,
      MODE_JOG         = 3'd4
   } shcj_mode_type;

   typedef struct packed {
      logic [PERIOD_W-1:0]   step_period_us;
      logic [DEBOUNCE_W-1:0] debounce_us;
      logic [DWELL_W-1:0]    dwell_us;
      logic [JOY_W-1:0]      joy_high;
      logic [JOY_W-1:0]      joy_low;
   } shcj_cfg_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [JOY_W-1:0]    joystick;
   } shcj_item_type;

   typedef struct packed {
      logic               enable_n;
      logic               step_level;
      logic               direction;
      logic [2:0]         mode;
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] middle;
   } shcj_result_type;

   // Status of the engine's state, for checks at the top level
   typedef struct packed {
      shcj_mode_type mode;
      logic          count_ge_middle;
   } shcj_status_type;

endpackage

FILE: src/shcj_if.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on shcj_pkg.
interface shcj_req_if;
   import shcj_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [JOY_W-1:0]    joystick;
   modport source (output valid, action, joystick, input ready);
   modport sink   (input valid, action, joystick, output ready);
endinterface

interface shcj_rsp_if;
   import shcj_pkg::*;
   logic               valid;
   logic               ready;
   logic               enable_n;
   logic               step_level;
   logic               direction;
   logic [2:0]         mode;
   logic [FIELD_W-1:0] position;
   logic [FIELD_W-1:0] middle;
   modport source (output valid, enable_n, step_level, direction, mode, position, middle,
                   input ready);
   modport sink   (input valid, enable_n, step_level, direction, mode, position, middle,
                   output ready);
endinterface

FILE: src/shcj_engine.sv
// Sequencer state and its combinational update for one tick or switch edge.
// Depends on shcj_pkg.
module shcj_engine #(
   parameter int COUNT_BITS = shcj_pkg::COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  shcj_pkg::shcj_item_type   item,
   input  shcj_pkg::shcj_cfg_type    cfg,
   output shcj_pkg::shcj_result_type result,
   output shcj_pkg::shcj_status_type status
);
   import shcj_pkg::*;

   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   shcj_mode_type           mode_ff, mode_in, mode_mid;
   logic                    await_ff, await_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in, count_dec;
   logic [COUNT_BITS-1:0]   middle_ff, middle_in;
   logic [PERIOD_W-1:0]     step_timer_ff, step_timer_in, period;
   logic [DEBOUNCE_W-1:0]   debounce_ff, debounce_in;
   logic [DWELL_W-1:0]      dwell_ff, dwell_in;
   logic                    step_ff, step_in;
   logic                    enable_ff, enable_in;
   logic                    dir_ff, dir_in;
   logic                    is_start, is_end, fire, passed, joy_hi, joy_lo;

   assign is_start  = (item.action == ACT_START);
   assign is_end    = (item.action == ACT_END);
   assign period    = (cfg.step_period_us == '0) ? PERIOD_W'(1) : cfg.step_period_us;
   assign fire      = ({1'b0, step_timer_ff} + (PERIOD_W+1)'(1)) >= {1'b0, period};
   assign passed    = debounce_ff > cfg.debounce_us;
   assign count_dec = (count_ff != '0) ? count_ff - COUNT_BITS'(1) : count_ff;
   assign joy_hi    = item.joystick > cfg.joy_high;
   assign joy_lo    = item.joystick < cfg.joy_low;
   // dwell expiry happens before the step firing within the same tick
   assign mode_mid  = (mode_ff == MODE_DWELL && dwell_ff >= cfg.dwell_us) ? MODE_JOG : mode_ff;

   always_comb begin
      mode_in       = mode_ff;
      await_in      = await_ff;
      count_in      = count_ff;
      middle_in     = middle_ff;
      step_timer_in = step_timer_ff;
      debounce_in   = debounce_ff;
      dwell_in      = dwell_ff;
      step_in       = step_ff;
      enable_in     = enable_ff;
      dir_in        = dir_ff;
      if (is_start || is_end) begin
         if (mode_ff != MODE_JOG) begin
            if (passed && is_start && await_ff) begin
               await_in = 1'b0;
               count_in = '0;
               mode_in  = MODE_SEEK_END;
            end else if (passed && is_end && !await_ff) begin
               await_in  = 1'b1;
               middle_in = count_ff >> 1;
               mode_in   = MODE_SEEK_MIDDLE;
            end
            debounce_in = '0;
         end
      end else begin
         if (debounce_ff < DEBOUNCE_MAX) begin
            debounce_in = debounce_ff + DEBOUNCE_W'(1);
         end
         mode_in = mode_mid;
         if (mode_ff == MODE_DWELL && dwell_ff < cfg.dwell_us) begin
            dwell_in = dwell_ff + DWELL_W'(1);
         end
         if (fire) begin
            step_timer_in = '0;
            case (mode_mid)
               MODE_SEEK_START: begin
                  enable_in = 1'b0;
                  step_in   = !step_ff;
                  dir_in    = 1'b0;
               end
               MODE_SEEK_END: begin
                  enable_in = 1'b0;
                  step_in   = !step_ff;
                  dir_in    = 1'b1;
                  if (count_ff != CountMax) begin
                     count_in = count_ff + COUNT_BITS'(1);
                  end
               end
               MODE_SEEK_MIDDLE: begin
                  enable_in = 1'b0;
                  step_in   = !step_ff;
                  dir_in    = 1'b0;
                  count_in  = count_dec;
                  if (count_dec <= middle_ff) begin
                     enable_in = 1'b1;
                     mode_in   = MODE_DWELL;
                     dwell_in  = '0;
                  end
               end
               MODE_JOG: begin
                  // both thresholds crossed: two toggles cancel, the low side wins (direction 0)
                  enable_in = !(joy_hi || joy_lo);
                  step_in   = step_ff ^ joy_hi ^ joy_lo;
                  dir_in    = joy_lo ? 1'b0 : (joy_hi ? 1'b1 : dir_ff);
               end
               default: begin
               end
            endcase
         end else begin
            step_timer_in = step_timer_ff + PERIOD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SEEK_START;
         await_ff      <= 1'b1;
         count_ff      <= '0;
         middle_ff     <= '0;
         step_timer_ff <= '0;
         debounce_ff   <= '0;
         dwell_ff      <= '0;
         step_ff       <= 1'b1;
         enable_ff     <= 1'b1;
         dir_ff        <= 1'b0;
      end else if (step_en) begin
         mode_ff       <= mode_in;
         await_ff      <= await_in;
         count_ff      <= count_in;
         middle_ff     <= middle_in;
         step_timer_ff <= step_timer_in;
         debounce_ff   <= debounce_in;
         dwell_ff      <= dwell_in;
         step_ff       <= step_in;
         enable_ff     <= enable_in;
         dir_ff        <= dir_in;
      end
   end

   assign result.enable_n   = enable_in;
   assign result.step_level = step_in;
   assign result.direction  = dir_in;
   assign result.mode       = mode_in;
   assign result.position   = FIELD_W'(count_in);
   assign result.middle     = FIELD_W'(middle_in);

   assign status.mode            = mode_ff;
   assign status.count_ge_middle = count_ff >= middle_ff;

endmodule

FILE: src/stepper_homing_centering_jog.sv
// Top level of the stepper homing, centering and jog sequencer.
// Depends on shcj_pkg, shcj_if and shcj_engine.

// Every request transaction is one microsecond tick (action 0, or the unused
// code 3) or a debounced falling edge of the start (1) or end (2) limit switch.
// The block homes to the start switch, runs to the end switch counting steps,
// returns to half of that travel, dwells, and then jogs by joystick level.
// Each request yields exactly one response carrying the step, direction and
// enable lines, the mode, the position and the computed middle, all as they
// stand after that request. Throughput is one transaction per clock while
// responses are taken; a request is registered, the sequencer state is updated
// from it combinationally, and the response is registered, so a response is
// offered once its held request advances, when the response register is free
// or being drained. The combinational state update of the sequencer sets that
// rate. While a response waits, one more request can be taken into the input
// register; then the request side stalls until the response is taken. CSR writes
// (index 0 step period, 1 debounce, 2 dwell, 3 joystick high, 4 joystick low)
// must be made only while the block is idle.
module stepper_homing_centering_jog #(
   parameter int COUNT_BITS = shcj_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   shcj_req_if.sink                         req_ch,
   shcj_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [shcj_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [shcj_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import shcj_pkg::*;

   shcj_cfg_type    cfg_ff;
   shcj_item_type   in_item_ff;
   logic            in_valid_ff;
   shcj_result_type out_ff, result;
   logic            out_valid_ff;
   logic            advance;
   shcj_status_type status;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_period_us <= STEP_PERIOD_RST;
         cfg_ff.debounce_us    <= DEBOUNCE_RST;
         cfg_ff.dwell_us       <= DWELL_RST;
         cfg_ff.joy_high       <= JOY_HIGH_RST;
         cfg_ff.joy_low        <= JOY_LOW_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_PERIOD: cfg_ff.step_period_us <= csr_wdata[PERIOD_W-1:0];
            CSR_DEBOUNCE:    cfg_ff.debounce_us    <= csr_wdata[DEBOUNCE_W-1:0];
            CSR_DWELL:       cfg_ff.dwell_us       <= csr_wdata[DWELL_W-1:0];
            CSR_JOY_HIGH:    cfg_ff.joy_high       <= csr_wdata[JOY_W-1:0];
            CSR_JOY_LOW:     cfg_ff.joy_low        <= csr_wdata[JOY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The held request is processed when the response register is free or
   // is being drained this cycle.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_item_ff.action   <= req_ch.action;
         in_item_ff.joystick <= req_ch.joystick;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   shcj_engine #(.COUNT_BITS(COUNT_BITS)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (result),
      .status  (status)
   );

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.enable_n   = out_ff.enable_n;
   assign rsp_ch.step_level = out_ff.step_level;
   assign rsp_ch.direction  = out_ff.direction;
   assign rsp_ch.mode       = out_ff.mode;
   assign rsp_ch.position   = out_ff.position;
   assign rsp_ch.middle     = out_ff.middle;

   // Jog is final until reset.
   a_jog_sticky: assert property (@(posedge clock) disable iff (reset)
      status.mode == MODE_JOG |=> status.mode == MODE_JOG)
      else $error("sequencer left jog mode");

   // Centering never goes below the middle it is heading for.
   a_center_bound: assert property (@(posedge clock) disable iff (reset)
      status.mode == MODE_SEEK_MIDDLE |-> status.count_ge_middle)
      else $error("position below middle while centering");

   // A held request with a stalled response must not let a new transaction in.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request accepted while pipeline is full");

   // The engine state moves only when a transaction is processed.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(status))
      else $error("sequencer state changed without a transaction");

endmodule
